@@ design/tdtd_pkg.sv @@
// Package for the two-axis deadband tracker drive: widths, reset values, codes and types.
`default_nettype none

package tdtd_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 12;
   localparam int CFG_W = 12;
   localparam int DUTY_W = 12;
   localparam int CSR_IDX_W = 3;

   localparam logic [CFG_W-1:0] START_THRESHOLD_RESET = 12'd100;
   localparam logic [CFG_W-1:0] STOP_THRESHOLD_RESET = 12'd75;
   localparam logic [CFG_W-1:0] FULL_SCALE_RESET = 12'd340;
   localparam logic [CFG_W-1:0] DUTY_MAX_RESET = 12'd742;
   localparam logic [CFG_W-1:0] DUTY_MIN_RESET = 12'd218;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_THRESHOLD = 3'd0,
      CSR_STOP_THRESHOLD = 3'd1,
      CSR_FULL_SCALE = 3'd2,
      CSR_DUTY_MAX = 3'd3,
      CSR_DUTY_MIN = 3'd4
   } csr_reg_type;

   typedef enum logic [2:0] {
      AXIS_IDLE,
      AXIS_MUL,
      AXIS_DIV,
      AXIS_FIN,
      AXIS_DONE
   } axis_state_type;

   typedef struct packed {
      logic [CFG_W-1:0] start_threshold;
      logic [CFG_W-1:0] stop_threshold;
      logic [CFG_W-1:0] full_scale;
      logic [CFG_W-1:0] duty_max;
      logic [CFG_W-1:0] duty_min;
   } cfg_type;

   typedef struct packed {
      logic done;
      logic [DUTY_W-1:0] duty;
      logic fwd;
      logic rev;
   } axis_result_type;

endpackage

`default_nettype wire

@@ design/tdtd_axis.sv @@
// One axis of the tracker drive: deadband decision and bit-serial scaled duty.
`default_nettype none

module tdtd_axis #(
   parameter int SAMPLE_BITS = tdtd_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic ack,
   input  wire logic signed [SAMPLE_BITS:0] diff,
   input  wire tdtd_pkg::cfg_type cfg,
   output tdtd_pkg::axis_result_type result
);

   localparam int DW = tdtd_pkg::DUTY_W;
   localparam int CMP_W = (SAMPLE_BITS > DW) ? SAMPLE_BITS : DW;
   localparam int STEPS = DW;
   localparam int CNT_W = $clog2(STEPS);
   localparam int SUM_W = DW + 2;
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

   tdtd_pkg::axis_state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] hi_ff, hi_in;
   logic [DW-1:0] lo_ff, lo_in;
   logic [DW-1:0] span_ff, span_in;
   logic neg_ff, neg_in;
   logic [DW-1:0] duty_ff, duty_in;
   logic [1:0] dirs_ff, dirs_in;

   logic [SAMPLE_BITS:0] mag_full;
   logic [CMP_W-1:0] mag;
   logic diff_pos;
   logic [DW:0] span_s;
   logic [DW:0] add_sum;
   logic [DW:0] rem_try;
   logic [DW:0] rem_sub;
   logic rem_ge;
   logic [SUM_W-1:0] quot_s;
   logic [SUM_W-1:0] duty_sum;

   always_comb begin
      mag_full = diff[SAMPLE_BITS] ? (~diff + 1'b1) : diff;
      mag = CMP_W'(mag_full[SAMPLE_BITS-1:0]);
      diff_pos = !diff[SAMPLE_BITS] && (diff != '0);
      span_s = {1'b0, cfg.duty_max} - {1'b0, cfg.duty_min};
      add_sum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, span_ff} : '0);
      rem_try = {hi_ff, lo_ff[DW-1]};
      rem_sub = rem_try - {1'b0, cfg.full_scale};
      rem_ge = rem_try >= {1'b0, cfg.full_scale};
      quot_s = neg_ff ? (SUM_W'(0) - {2'b00, lo_ff}) : {2'b00, lo_ff};
      duty_sum = {2'b00, cfg.duty_min} + quot_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tdtd_pkg::AXIS_IDLE;
         duty_ff <= '0;
         dirs_ff <= '0;
      end else begin
         state_ff <= state_in;
         duty_ff <= duty_in;
         dirs_ff <= dirs_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
      span_ff <= span_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      hi_in = hi_ff;
      lo_in = lo_ff;
      span_in = span_ff;
      neg_in = neg_ff;
      duty_in = duty_ff;
      dirs_in = dirs_ff;
      case (state_ff)
         tdtd_pkg::AXIS_IDLE: begin
            if (start) begin
               state_in = tdtd_pkg::AXIS_DONE;
               if (mag >= CMP_W'(cfg.start_threshold)) begin
                  dirs_in = diff_pos ? 2'b01 : 2'b10;
                  if (mag > CMP_W'(cfg.full_scale)) begin
                     duty_in = cfg.duty_max;
                  end else if (cfg.full_scale == '0) begin
                     // Only a zero magnitude gets here; the quotient counts as zero.
                     duty_in = cfg.duty_min;
                  end else begin
                     state_in = tdtd_pkg::AXIS_MUL;
                     cnt_in = '0;
                     hi_in = '0;
                     lo_in = mag[DW-1:0];
                     neg_in = span_s[DW];
                     span_in = span_s[DW] ? DW'(~span_s + 1'b1) : span_s[DW-1:0];
                  end
               end else if (mag < CMP_W'(cfg.stop_threshold)) begin
                  duty_in = '0;
                  dirs_in = '0;
               end
            end
         end
         tdtd_pkg::AXIS_MUL: begin
            hi_in = add_sum[DW:1];
            lo_in = {add_sum[0], lo_ff[DW-1:1]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               cnt_in = '0;
               state_in = tdtd_pkg::AXIS_DIV;
            end
         end
         tdtd_pkg::AXIS_DIV: begin
            hi_in = rem_ge ? rem_sub[DW-1:0] : rem_try[DW-1:0];
            lo_in = {lo_ff[DW-2:0], rem_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               cnt_in = '0;
               state_in = tdtd_pkg::AXIS_FIN;
            end
         end
         tdtd_pkg::AXIS_FIN: begin
            if (duty_sum[SUM_W-1]) begin
               duty_in = '0;
            end else if (duty_sum[SUM_W-2]) begin
               duty_in = '1;
            end else begin
               duty_in = duty_sum[DW-1:0];
            end
            state_in = tdtd_pkg::AXIS_DONE;
         end
         tdtd_pkg::AXIS_DONE: begin
            if (ack) begin
               state_in = tdtd_pkg::AXIS_IDLE;
            end
         end
         default: begin
            state_in = tdtd_pkg::AXIS_IDLE;
         end
      endcase
   end

   assign result.done = (state_ff == tdtd_pkg::AXIS_DONE);
   assign result.duty = duty_ff;
   assign result.fwd = dirs_ff[0];
   assign result.rev = dirs_ff[1];

endmodule

`default_nettype wire

@@ design/two_axis_deadband_tracker_drive.sv @@
// Top level of the two-axis deadband tracker drive: handshakes, registers, output beat.
//
//   channel   direction  handshake               payload
//   req_      in         req_valid / req_ready   north, south, east, west levels
//   rsp_      out        rsp_valid / rsp_ready   tilt and pan duty and direction lines
//   csr_      in         csr_write_en            csr_index, csr_wdata (12 bits)
//
// A beat whose axes both land outside the proportional range (full drive, stop or
// hold) goes from acceptance straight to each axis's done state. A proportional
// beat runs 12 shift-add multiply steps and 12 restoring divide steps in each
// axis engine, then a clamp step, before its done state. The next request beat is
// taken once the previous result has moved into the output register, so a stalled
// consumer holds back at most one further beat. Reset is synchronous, active high,
// and restores the register defaults and zero held outputs.
`default_nettype none

module two_axis_deadband_tracker_drive #(
   parameter int SAMPLE_BITS = tdtd_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [SAMPLE_BITS-1:0] req_north_level,
   input  wire logic [SAMPLE_BITS-1:0] req_south_level,
   input  wire logic [SAMPLE_BITS-1:0] req_east_level,
   input  wire logic [SAMPLE_BITS-1:0] req_west_level,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic [tdtd_pkg::DUTY_W-1:0] rsp_tilt_duty,
   output logic rsp_tilt_dir_fwd,
   output logic rsp_tilt_dir_rev,
   output logic [tdtd_pkg::DUTY_W-1:0] rsp_pan_duty,
   output logic rsp_pan_dir_fwd,
   output logic rsp_pan_dir_rev,
   input  wire logic csr_write_en,
   input  wire logic [tdtd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [tdtd_pkg::CFG_W-1:0] csr_wdata
);

   tdtd_pkg::cfg_type cfg_ff, cfg_in;

   // The busy flag covers a beat from acceptance until its result is registered.
   logic busy_ff, busy_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [tdtd_pkg::DUTY_W-1:0] tilt_duty_ff, pan_duty_ff;
   logic tilt_fwd_ff, tilt_rev_ff, pan_fwd_ff, pan_rev_ff;

   logic accept;
   logic load;
   logic signed [SAMPLE_BITS:0] tilt_diff;
   logic signed [SAMPLE_BITS:0] pan_diff;
   tdtd_pkg::axis_result_type tilt_res;
   tdtd_pkg::axis_result_type pan_res;

   assign req_ready = !busy_ff;
   assign accept = req_valid && req_ready;

   // The result moves to the output register once both axes have finished and the
   // register is empty or being emptied in the same cycle.
   assign load = tilt_res.done && pan_res.done && (!rsp_valid_ff || rsp_ready);

   assign tilt_diff = $signed({1'b0, req_north_level}) - $signed({1'b0, req_south_level});
   assign pan_diff = $signed({1'b0, req_east_level}) - $signed({1'b0, req_west_level});

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            tdtd_pkg::CSR_START_THRESHOLD: cfg_in.start_threshold = csr_wdata;
            tdtd_pkg::CSR_STOP_THRESHOLD: cfg_in.stop_threshold = csr_wdata;
            tdtd_pkg::CSR_FULL_SCALE: cfg_in.full_scale = csr_wdata;
            tdtd_pkg::CSR_DUTY_MAX: cfg_in.duty_max = csr_wdata;
            tdtd_pkg::CSR_DUTY_MIN: cfg_in.duty_min = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (load) begin
         busy_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_threshold <= tdtd_pkg::START_THRESHOLD_RESET;
         cfg_ff.stop_threshold <= tdtd_pkg::STOP_THRESHOLD_RESET;
         cfg_ff.full_scale <= tdtd_pkg::FULL_SCALE_RESET;
         cfg_ff.duty_max <= tdtd_pkg::DUTY_MAX_RESET;
         cfg_ff.duty_min <= tdtd_pkg::DUTY_MIN_RESET;
         busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         busy_ff <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload registers need no reset; they are only seen with rsp_valid.
   always_ff @(posedge clock) begin
      if (load) begin
         tilt_duty_ff <= tilt_res.duty;
         tilt_fwd_ff <= tilt_res.fwd;
         tilt_rev_ff <= tilt_res.rev;
         pan_duty_ff <= pan_res.duty;
         pan_fwd_ff <= pan_res.fwd;
         pan_rev_ff <= pan_res.rev;
      end
   end

   tdtd_axis #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_tilt (
      .clock(clock),
      .reset(reset),
      .start(accept),
      .ack(load),
      .diff(tilt_diff),
      .cfg(cfg_ff),
      .result(tilt_res)
   );

   tdtd_axis #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_pan (
      .clock(clock),
      .reset(reset),
      .start(accept),
      .ack(load),
      .diff(pan_diff),
      .cfg(cfg_ff),
      .result(pan_res)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_tilt_duty = tilt_duty_ff;
   assign rsp_tilt_dir_fwd = tilt_fwd_ff;
   assign rsp_tilt_dir_rev = tilt_rev_ff;
   assign rsp_pan_duty = pan_duty_ff;
   assign rsp_pan_dir_fwd = pan_fwd_ff;
   assign rsp_pan_dir_rev = pan_rev_ff;

`ifndef NO_ASSERTIONS
   // An accepted beat keeps the input side closed until its result is registered.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("request taken while a beat is in flight");

   // A finished axis always belongs to a beat that is still in flight.
   a_done_means_busy: assert property (@(posedge clock) disable iff (reset)
      (tilt_res.done || pan_res.done) |-> busy_ff)
      else $error("axis finished with no beat in flight");

   // An axis never drives both bridge inputs.
   a_dirs_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_tilt_dir_fwd && rsp_tilt_dir_rev) &&
                    !(rsp_pan_dir_fwd && rsp_pan_dir_rev))
      else $error("both direction lines high");

   // A stopped tilt axis reports zero duty.
   a_stop_zero_duty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_tilt_dir_fwd && !rsp_tilt_dir_rev) |-> (rsp_tilt_duty == '0))
      else $error("tilt duty nonzero while stopped");
`endif

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the two-axis deadband tracker drive.
`timescale 1ns / 1ps

module testbench;

   localparam int SAMPLE_BITS = tdtd_pkg::SAMPLE_BITS_DEFAULT;
   localparam int DUTY_W = tdtd_pkg::DUTY_W;
   localparam int CFG_W = tdtd_pkg::CFG_W;
   localparam int CSR_IDX_W = tdtd_pkg::CSR_IDX_W;
   localparam int LEVEL_MAX = (1 << SAMPLE_BITS) - 1;
   localparam int DUTY_CEILING = (1 << DUTY_W) - 1;
   localparam int CYCLE_LIMIT = 900000;
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_PER_PHASE = 240;
   // Indexes past the register list; writes there must leave the setup alone.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LOW = 3'd5;
   localparam int CSR_UNUSED_SPAN = 2;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] north;
      logic [SAMPLE_BITS-1:0] south;
      logic [SAMPLE_BITS-1:0] east;
      logic [SAMPLE_BITS-1:0] west;
   } level_set_type;

   typedef struct packed {
      logic [DUTY_W-1:0] duty;
      logic fwd;
      logic rev;
   } axis_drive_type;

   typedef struct packed {
      axis_drive_type tilt;
      axis_drive_type pan;
   } drive_beat_type;

   // Receiver behaviors; each one lasts for a random stretch of cycles.
   typedef enum logic [1:0] {
      SINK_OPEN,
      SINK_COIN,
      SINK_SHORT_BEAT,
      SINK_LONG_HOLD
   } sink_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_ready;
   logic [SAMPLE_BITS-1:0] req_north_level = '0;
   logic [SAMPLE_BITS-1:0] req_south_level = '0;
   logic [SAMPLE_BITS-1:0] req_east_level = '0;
   logic [SAMPLE_BITS-1:0] req_west_level = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [DUTY_W-1:0] rsp_tilt_duty;
   logic rsp_tilt_dir_fwd;
   logic rsp_tilt_dir_rev;
   logic [DUTY_W-1:0] rsp_pan_duty;
   logic rsp_pan_dir_fwd;
   logic rsp_pan_dir_rev;
   logic csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_wdata = '0;

   two_axis_deadband_tracker_drive #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_north_level(req_north_level),
      .req_south_level(req_south_level),
      .req_east_level(req_east_level),
      .req_west_level(req_west_level),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_tilt_duty(rsp_tilt_duty),
      .rsp_tilt_dir_fwd(rsp_tilt_dir_fwd),
      .rsp_tilt_dir_rev(rsp_tilt_dir_rev),
      .rsp_pan_duty(rsp_pan_duty),
      .rsp_pan_dir_fwd(rsp_pan_dir_fwd),
      .rsp_pan_dir_rev(rsp_pan_dir_rev),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Level sets waiting to be offered, and drive beats waiting to come out.
   level_set_type pending_levels[$];
   drive_beat_type expected_drive[$];

   // Our own copy of the register file and of the held axis outputs.
   tdtd_pkg::cfg_type drive_cfg;
   axis_drive_type tilt_held;
   axis_drive_type pan_held;

   int mismatch_count = 0;
   int unsigned cycle_count = 0;

   // Set by the monitor when the request beat on the bus was taken at the last rising edge.
   logic req_taken = 1'b0;

   // Sender pacing: bursts of beats separated by idle gaps.
   int burst_left = 1;
   int gap_left = 0;
   bit sender_calm = 1'b0;
   level_set_type next_levels;

   // Receiver pacing.
   sink_mode_type sink_mode = SINK_OPEN;
   int sink_span = 0;
   int sink_tick = 0;
   bit receiver_calm = 1'b0;

   drive_beat_type got_beat;
   drive_beat_type want_beat;

   // The clock runs free; the first rising edge comes half a period in.
   initial begin
      forever #10 clock = ~clock;
   end

   // A hung handshake ends the run here.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("two_axis_deadband_tracker_drive verification failed");
      $finish;
   end

   task automatic note_mismatch(input string what, input int want, input int got);
      $display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
      mismatch_count++;
   endtask

   // One axis of the drive law. A magnitude at or above the start threshold
   // always drives, even when start sits at or below stop; below stop the axis
   // goes quiet; anything in between keeps what the axis had.
   function automatic axis_drive_type update_axis(input longint diff,
                                                  input axis_drive_type held);
      longint mag;
      longint span;
      longint quot;
      longint duty;
      axis_drive_type next;
      next = held;
      mag = (diff < 0) ? -diff : diff;
      if (mag >= longint'(drive_cfg.start_threshold)) begin
         // A zero difference is not positive, so it drives the reverse line.
         next.fwd = (diff > 0);
         next.rev = !(diff > 0);
         if (mag > longint'(drive_cfg.full_scale)) begin
            next.duty = drive_cfg.duty_max;
         end else begin
            span = longint'(drive_cfg.duty_max) - longint'(drive_cfg.duty_min);
            // A zero full scale only gets here with a zero magnitude: no divide.
            quot = 0;
            if (drive_cfg.full_scale != '0) begin
               quot = (span * mag) / longint'(drive_cfg.full_scale);
            end
            duty = longint'(drive_cfg.duty_min) + quot;
            if (duty < 0) begin
               duty = 0;
            end
            if (duty > DUTY_CEILING) begin
               duty = DUTY_CEILING;
            end
            next.duty = duty[DUTY_W-1:0];
         end
      end else if (mag < longint'(drive_cfg.stop_threshold)) begin
         next = '0;
      end
      return next;
   endfunction

   // Monitor: sampled at the rising edge. It tracks register writes, predicts a
   // drive beat for every request beat taken, and checks every response beat.
   always @(posedge clock) begin
      if (reset) begin
         drive_cfg.start_threshold = tdtd_pkg::START_THRESHOLD_RESET;
         drive_cfg.stop_threshold = tdtd_pkg::STOP_THRESHOLD_RESET;
         drive_cfg.full_scale = tdtd_pkg::FULL_SCALE_RESET;
         drive_cfg.duty_max = tdtd_pkg::DUTY_MAX_RESET;
         drive_cfg.duty_min = tdtd_pkg::DUTY_MIN_RESET;
         tilt_held = '0;
         pan_held = '0;
         expected_drive.delete();
         req_taken <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               tdtd_pkg::CSR_START_THRESHOLD: drive_cfg.start_threshold = csr_wdata;
               tdtd_pkg::CSR_STOP_THRESHOLD: drive_cfg.stop_threshold = csr_wdata;
               tdtd_pkg::CSR_FULL_SCALE: drive_cfg.full_scale = csr_wdata;
               tdtd_pkg::CSR_DUTY_MAX: drive_cfg.duty_max = csr_wdata;
               tdtd_pkg::CSR_DUTY_MIN: drive_cfg.duty_min = csr_wdata;
               default: ;
            endcase
         end
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            tilt_held = update_axis(longint'(req_north_level) - longint'(req_south_level),
                                    tilt_held);
            pan_held = update_axis(longint'(req_east_level) - longint'(req_west_level),
                                   pan_held);
            expected_drive.push_back('{tilt: tilt_held, pan: pan_held});
         end
         if (rsp_valid && rsp_ready) begin
            got_beat.tilt = '{duty: rsp_tilt_duty, fwd: rsp_tilt_dir_fwd,
                              rev: rsp_tilt_dir_rev};
            got_beat.pan = '{duty: rsp_pan_duty, fwd: rsp_pan_dir_fwd,
                             rev: rsp_pan_dir_rev};
            if (expected_drive.size() == 0) begin
               note_mismatch("response beat with none outstanding", 0, 1);
            end else begin
               want_beat = expected_drive.pop_front();
               if (got_beat.tilt.duty !== want_beat.tilt.duty) begin
                  note_mismatch("tilt_duty", int'(want_beat.tilt.duty),
                                int'(got_beat.tilt.duty));
               end
               if (got_beat.tilt.fwd !== want_beat.tilt.fwd) begin
                  note_mismatch("tilt_dir_fwd", int'(want_beat.tilt.fwd),
                                int'(got_beat.tilt.fwd));
               end
               if (got_beat.tilt.rev !== want_beat.tilt.rev) begin
                  note_mismatch("tilt_dir_rev", int'(want_beat.tilt.rev),
                                int'(got_beat.tilt.rev));
               end
               if (got_beat.pan.duty !== want_beat.pan.duty) begin
                  note_mismatch("pan_duty", int'(want_beat.pan.duty),
                                int'(got_beat.pan.duty));
               end
               if (got_beat.pan.fwd !== want_beat.pan.fwd) begin
                  note_mismatch("pan_dir_fwd", int'(want_beat.pan.fwd),
                                int'(got_beat.pan.fwd));
               end
               if (got_beat.pan.rev !== want_beat.pan.rev) begin
                  note_mismatch("pan_dir_rev", int'(want_beat.pan.rev),
                                int'(got_beat.pan.rev));
               end
            end
         end
      end
   end

   // Driver: changes the request side at the falling edge. A beat on the bus
   // stays put until the monitor has seen it taken; after that the next beat
   // goes out, or the sender idles if its burst has run out.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left <= 1;
         gap_left <= 0;
      end else if (req_valid && !req_taken) begin
         // Holding the current beat.
      end else if (gap_left != 0) begin
         req_valid <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (pending_levels.size() != 0) begin
         next_levels = pending_levels.pop_front();
         req_valid <= 1'b1;
         req_north_level <= next_levels.north;
         req_south_level <= next_levels.south;
         req_east_level <= next_levels.east;
         req_west_level <= next_levels.west;
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            // About a quarter of the bursts run straight into the next one.
            if (sender_calm || $urandom_range(0, 3) == 0) begin
               gap_left <= 0;
            end else begin
               gap_left <= $urandom_range(1, 10);
            end
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Receiver: ready follows one of a few patterns, switching every so often,
   // so stalls land on every phase of the block's work.
   always @(negedge clock) begin
      if (sink_span == 0) begin
         sink_mode <= receiver_calm ? SINK_OPEN : sink_mode_type'($urandom_range(0, 3));
         sink_span <= $urandom_range(32, 200);
      end else begin
         sink_span <= sink_span - 1;
      end
      sink_tick <= sink_tick + 1;
      case (sink_mode)
         SINK_OPEN: rsp_ready <= 1'b1;
         SINK_COIN: rsp_ready <= 1'($urandom_range(0, 1));
         SINK_SHORT_BEAT: rsp_ready <= (sink_tick % 7) > 2;
         default: rsp_ready <= (sink_tick % 29) >= 12;
      endcase
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input int value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value[CFG_W-1:0];
   endtask

   // Writes the whole register set, with a stray write past the list slipped in.
   task automatic program_drive(input int start_thr, input int stop_thr, input int full,
                                input int dmax, input int dmin);
      write_csr(tdtd_pkg::CSR_START_THRESHOLD, start_thr);
      write_csr(tdtd_pkg::CSR_STOP_THRESHOLD, stop_thr);
      write_csr(CSR_IDX_W'(CSR_UNUSED_LOW + $urandom_range(0, CSR_UNUSED_SPAN)),
                $urandom_range(0, 4095));
      write_csr(tdtd_pkg::CSR_FULL_SCALE, full);
      write_csr(tdtd_pkg::CSR_DUTY_MAX, dmax);
      write_csr(tdtd_pkg::CSR_DUTY_MIN, dmin);
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic queue_levels(input int north, input int south, input int east,
                               input int west);
      pending_levels.push_back('{north: north[SAMPLE_BITS-1:0], south: south[SAMPLE_BITS-1:0],
                                 east: east[SAMPLE_BITS-1:0], west: west[SAMPLE_BITS-1:0]});
   endtask

   // Waits until every beat is out and checked, then lets the pipeline go quiet.
   // The queues are looked at on the rising edge, where the driver never moves.
   task automatic drain_drive;
      @(posedge clock);
      while (pending_levels.size() != 0 || req_valid || expected_drive.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic int near_level(input int center);
      int v;
      v = center + $urandom_range(0, 6) - 3;
      if (v < 0) begin
         v = 0;
      end
      if (v > LEVEL_MAX) begin
         v = LEVEL_MAX;
      end
      return v;
   endfunction

   // Picks the two levels of one axis. Four in ten picks aim the difference at the
   // thresholds and the full-scale knee in the current setup, so the axes keep
   // crossing between drive, hold and stop.
   task automatic pick_axis_levels(output int plus_lvl, output int minus_lvl);
      int mag;
      int base;
      int cap;
      cap = int'(drive_cfg.full_scale) + 8;
      if (cap > LEVEL_MAX) begin
         cap = LEVEL_MAX;
      end
      case ($urandom_range(0, 9))
         0, 1: mag = near_level(int'(drive_cfg.start_threshold));
         2: mag = near_level(int'(drive_cfg.stop_threshold));
         3: mag = near_level(int'(drive_cfg.full_scale));
         4: mag = 0;
         5: mag = LEVEL_MAX;
         6, 7: mag = $urandom_range(0, cap);
         default: mag = -1;
      endcase
      if (mag < 0) begin
         plus_lvl = $urandom_range(0, LEVEL_MAX);
         minus_lvl = $urandom_range(0, LEVEL_MAX);
      end else begin
         base = $urandom_range(0, LEVEL_MAX - mag);
         if ($urandom_range(0, 1) == 1) begin
            plus_lvl = base + mag;
            minus_lvl = base;
         end else begin
            plus_lvl = base;
            minus_lvl = base + mag;
         end
      end
   endtask

   task automatic run_random_phase(input int start_thr, input int stop_thr, input int full,
                                   input int dmax, input int dmin, input bit calm_send,
                                   input bit calm_sink);
      int north;
      int south;
      int east;
      int west;
      program_drive(start_thr, stop_thr, full, dmax, dmin);
      sender_calm = calm_send;
      receiver_calm = calm_sink;
      repeat (RANDOM_PER_PHASE) begin
         pick_axis_levels(north, south);
         pick_axis_levels(east, west);
         queue_levels(north, south, east, west);
      end
      drain_drive();
   endtask

   initial begin
      int start_thr;
      int stop_thr;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats under the reset setup: 100 start, 75 stop, 340 full,
      // duty 218 to 742. The tilt axis is north minus south, pan east minus west.
      queue_levels(0, 0, 0, 0);
      queue_levels(LEVEL_MAX, 0, 0, LEVEL_MAX);
      queue_levels(200, 100, 100, 200);
      // The next two land in the hold band on both axes; the third lands in the stop band.
      queue_levels(199, 100, 120, 200);
      queue_levels(175, 100, 100, 175);
      queue_levels(174, 100, 50, 50);
      // Exactly full scale stays proportional; one past it clamps to the maximum.
      queue_levels(340, 0, 0, 341);
      queue_levels(0, LEVEL_MAX, LEVEL_MAX, 0);
      queue_levels(1250, 1000, 830, 1000);
      queue_levels(LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX);
      queue_levels('hAAA, 'h555, 'h555, 'hAAA);
      drain_drive();

      // Start below stop: no hold band, and a drive can start under the stop level.
      program_drive(50, 200, 400, 1000, 100);
      queue_levels(160, 100, 250, 100);
      queue_levels(140, 100, 499, 300);
      drain_drive();

      // Zero start and zero full scale: a zero difference drives in reverse at
      // the minimum duty, any other difference at the maximum.
      program_drive(0, 0, 0, 900, 300);
      queue_levels(7, 7, 3000, 3000);
      queue_levels(1, 0, 0, LEVEL_MAX);
      drain_drive();

      // Maximum below minimum: the span is negative and the quotient truncates
      // toward zero.
      program_drive(10, 5, 1000, 100, 3000);
      queue_levels(500, 0, 1, 1000);
      queue_levels(2001, 1000, 7, 0);
      drain_drive();

      // Duty at the top of its range.
      program_drive(1, 0, 1, 4095, 4095);
      queue_levels(1, 0, 4094, LEVEL_MAX);
      drain_drive();

      // Random phases over a spread of setups, the register extremes among them.
      run_random_phase(100, 75, 340, 742, 218, 1'b0, 1'b0);
      run_random_phase(4095, 4095, 4095, 4095, 0, 1'b0, 1'b1);
      run_random_phase(1, 0, 1, 0, 4095, 1'b1, 1'b0);
      start_thr = $urandom_range(1, 4095);
      run_random_phase(start_thr, $urandom_range(0, start_thr), $urandom_range(1, 4095),
                       $urandom_range(0, 4095), $urandom_range(0, 4095), 1'b0, 1'b0);
      stop_thr = $urandom_range(1, 4095);
      run_random_phase($urandom_range(0, stop_thr), stop_thr, $urandom_range(1, 4095),
                       $urandom_range(0, 4095), $urandom_range(0, 4095), 1'b1, 1'b1);
      run_random_phase(0, 0, 0, $urandom_range(0, 4095), $urandom_range(0, 4095),
                       1'b0, 1'b0);
      start_thr = $urandom_range(1, 300);
      run_random_phase(start_thr, $urandom_range(0, start_thr), $urandom_range(1, 600),
                       $urandom_range(0, 4095), $urandom_range(0, 4095), 1'b0, 1'b0);
      run_random_phase($urandom_range(0, 4095), $urandom_range(0, 4095),
                       $urandom_range(0, 4095), $urandom_range(0, 4095),
                       $urandom_range(0, 4095), 1'b0, 1'b0);

      if (mismatch_count == 0) begin
         $display("two_axis_deadband_tracker_drive verification clean");
      end else begin
         $display("two_axis_deadband_tracker_drive verification failed");
      end
      $finish;
   end

endmodule
